@@ rtl/hpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// hpsf_pkg
// shared types and constants of the hashed pte slot finder
// ----------------------------------------------------------------------------
package hpsf_pkg;

   // default number of groups in the table
   localparam int NUM_GROUPS_DEF  = 1024;
   // slots in one group, fixed by the table format
   localparam int SLOTS_PER_GROUP = 8;
   localparam int LANE_W          = 3;

   // field widths
   localparam int WORD_W   = 32;
   localparam int SLOT_W   = 13;
   localparam int GROUP_W  = 10;
   localparam int OUTC_W   = 3;
   localparam int CSR_IDX_W = 1;

   // pte word bits
   localparam logic [WORD_W-1:0] H_BIT = 32'h0000_0040;
   localparam int                V_POS = 31;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_FIND  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_MASK = 1'b1;

   localparam logic [GROUP_W-1:0] GROUP_MASK_RESET = 10'h3ff;

   typedef logic [SLOTS_PER_GROUP-1:0][WORD_W-1:0] group_type;

   typedef enum logic [OUTC_W-1:0] {
      OUT_MATCH_P    = 3'd0,
      OUT_MATCH_S    = 3'd1,
      OUT_FREE_P     = 3'd2,
      OUT_FREE_S     = 3'd3,
      OUT_STOLEN     = 3'd4,
      OUT_WRITE_DONE = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_WRITE,
      ST_READ_P,
      ST_READ_S,
      ST_EVAL
   } state_type;

endpackage

@@ rtl/hpsf_req_if.sv @@
// ----------------------------------------------------------------------------
// hpsf_req_if
// request channel of the hashed pte slot finder
// ----------------------------------------------------------------------------
interface hpsf_req_if;

   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [hpsf_pkg::WORD_W-1:0]  address;
   logic [hpsf_pkg::WORD_W-1:0]  entry_word;
   logic                         present;
   logic [hpsf_pkg::SLOT_W-1:0]  write_slot;

   modport source (
      output valid, cmd, address, entry_word, present, write_slot,
      input  ready
   );

   modport sink (
      input  valid, cmd, address, entry_word, present, write_slot,
      output ready
   );

endinterface

@@ rtl/hpsf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hpsf_rsp_if
// result channel of the hashed pte slot finder
// ----------------------------------------------------------------------------
interface hpsf_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [hpsf_pkg::WORD_W-1:0]  slot_address;
   logic [hpsf_pkg::SLOT_W-1:0]  slot_number;
   logic [hpsf_pkg::WORD_W-1:0]  entry_out;
   logic                         replaced;
   logic [hpsf_pkg::OUTC_W-1:0]  outcome;

   modport source (
      output valid, slot_address, slot_number, entry_out, replaced, outcome,
      input  ready
   );

   modport sink (
      input  valid, slot_address, slot_number, entry_out, replaced, outcome,
      output ready
   );

endinterface

@@ rtl/hashed_pte_slot_finder_top.sv @@
// ----------------------------------------------------------------------------
// hashed_pte_slot_finder_top
// hashed page table of first pte words with slot search for new entries
// ----------------------------------------------------------------------------
// The table lives in one synchronous memory of NUM_GROUPS rows, each row a
// whole group of eight 32-bit pte words, so one read returns a full group.
// After reset a clearing pass writes zero to one row per cycle; no request is
// taken until it is done (csr writes are taken at any time). One request is
// worked on at a time. A find runs through these steps: the accepting cycle
// hashes, the reduce state folds the group index into the table, then one
// memory read for the primary group and one for the secondary group on the
// single read port, and the eval state searches both groups, picks the slot
// and loads the output register. A write has its group index folded in the
// reduce state and is then, in the write state, written to the table and
// loaded into the output register.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits on rsp_bus.ready; a result that cannot
// leave holds the block until the output register frees up. csr writes must
// only happen while the block is idle. The table base is meant to be aligned
// to the table size; a find forms slot_address by or and xor with it, a write by adding to it.
// ----------------------------------------------------------------------------
module hashed_pte_slot_finder_top #(
   parameter int NUM_GROUPS = hpsf_pkg::NUM_GROUPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   hpsf_req_if.sink                        req_bus,
   hpsf_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [hpsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpsf_pkg::WORD_W-1:0]     csr_wdata
);

   // row address width of the table memory
   localparam int ROW_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_GROUPS - 1);

   // group indexes are 10 bits wide; fold them into the table when it is
   // smaller, by a reciprocal multiply that is exact for 10-bit values
   localparam bit RED_NEEDED = (NUM_GROUPS < (1 << hpsf_pkg::GROUP_W));
   localparam int RED_SHIFT  = 2 * hpsf_pkg::GROUP_W;
   localparam int RED_MULT_I = RED_NEEDED ?
                               (((1 << RED_SHIFT) + NUM_GROUPS - 1) / NUM_GROUPS) : 1;
   localparam logic [RED_SHIFT:0]               RED_MULT = (RED_SHIFT + 1)'(RED_MULT_I);
   localparam logic [hpsf_pkg::GROUP_W-1:0]     RED_DIV  =
      hpsf_pkg::GROUP_W'(RED_NEEDED ? NUM_GROUPS : 1);
   localparam int PROD_W = hpsf_pkg::GROUP_W + RED_SHIFT + 1;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [hpsf_pkg::WORD_W-1:0]  table_base_ff;
   logic [hpsf_pkg::GROUP_W-1:0] group_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
         group_mask_ff <= hpsf_pkg::GROUP_MASK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hpsf_pkg::CSR_TABLE_BASE: table_base_ff <= csr_wdata;
            hpsf_pkg::CSR_GROUP_MASK: group_mask_ff <= csr_wdata[hpsf_pkg::GROUP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   hpsf_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0]    clr_row_ff;
   logic [2:0]          steal_ff, steal_in;

   logic req_take;
   logic out_free;
   logic out_load;

   assign req_bus.ready = (state_ff == hpsf_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   // request payload held for the whole search
   logic                          cmd_ff;
   logic [hpsf_pkg::WORD_W-1:0]   entry_ff;
   logic                          present_ff;
   logic [hpsf_pkg::SLOT_W-1:0]   wslot_ff;
   // raw group indexes (primary, secondary); for a write the slot's group
   logic [hpsf_pkg::GROUP_W-1:0]  grp_p_ff, grp_s_ff;
   logic [hpsf_pkg::GROUP_W-1:0]  q_p_ff, q_s_ff;
   // group indexes folded into the table
   logic [hpsf_pkg::GROUP_W-1:0]  red_p_ff, red_s_ff;

   // ---------------------------------------------------------------------
   // hash and quotient at acceptance
   // ---------------------------------------------------------------------
   logic [hpsf_pkg::GROUP_W-1:0] hash_p;
   logic [hpsf_pkg::GROUP_W-1:0] g_p_in, g_s_in;
   logic [PROD_W-1:0]            prod_p, prod_s;

   always_comb begin
      // page index bits 21..12 against vsid bits 16..7, masked to the table
      hash_p = (req_bus.address[21:12] ^ req_bus.entry_word[16:7]) & group_mask_ff;
      g_p_in = (req_bus.cmd == hpsf_pkg::CMD_FIND) ? hash_p : req_bus.write_slot[12:3];
      g_s_in = hash_p ^ group_mask_ff;
      prod_p = PROD_W'(g_p_in) * PROD_W'(RED_MULT);
      prod_s = PROD_W'(g_s_in) * PROD_W'(RED_MULT);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_bus.cmd;
         entry_ff   <= req_bus.entry_word;
         present_ff <= req_bus.present;
         wslot_ff   <= req_bus.write_slot;
         grp_p_ff   <= g_p_in;
         grp_s_ff   <= g_s_in;
         q_p_ff     <= prod_p[RED_SHIFT +: hpsf_pkg::GROUP_W];
         q_s_ff     <= prod_s[RED_SHIFT +: hpsf_pkg::GROUP_W];
      end
   end

   // ---------------------------------------------------------------------
   // remainder stage
   // ---------------------------------------------------------------------
   logic [2*hpsf_pkg::GROUP_W-1:0] qn_p, qn_s;
   logic [hpsf_pkg::GROUP_W-1:0]   red_p_in, red_s_in;

   always_comb begin
      qn_p = (2*hpsf_pkg::GROUP_W)'(q_p_ff) * (2*hpsf_pkg::GROUP_W)'(RED_DIV);
      qn_s = (2*hpsf_pkg::GROUP_W)'(q_s_ff) * (2*hpsf_pkg::GROUP_W)'(RED_DIV);
      if (RED_NEEDED) begin
         red_p_in = grp_p_ff - qn_p[hpsf_pkg::GROUP_W-1:0];
         red_s_in = grp_s_ff - qn_s[hpsf_pkg::GROUP_W-1:0];
      end else begin
         red_p_in = grp_p_ff;
         red_s_in = grp_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == hpsf_pkg::ST_REDUCE) begin
         red_p_ff <= red_p_in;
         red_s_ff <= red_s_in;
      end
   end

   // ---------------------------------------------------------------------
   // table memory, one group per row
   // ---------------------------------------------------------------------
   hpsf_pkg::group_type mem [NUM_GROUPS];
   hpsf_pkg::group_type rd_data_ff;
   hpsf_pkg::group_type prim_ff;

   logic             rd_en;
   logic [ROW_W-1:0] rd_addr;
   logic             clr_we;
   logic             wr_we;

   always_comb begin
      rd_en   = (state_ff == hpsf_pkg::ST_READ_P) || (state_ff == hpsf_pkg::ST_READ_S);
      rd_addr = (state_ff == hpsf_pkg::ST_READ_S) ? ROW_W'(red_s_ff) : ROW_W'(red_p_ff);
      clr_we  = (state_ff == hpsf_pkg::ST_CLEAR);
      wr_we   = (state_ff == hpsf_pkg::ST_WRITE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (clr_we) begin
         mem[clr_row_ff] <= '0;
      end else if (wr_we) begin
         mem[ROW_W'(red_p_ff)][wslot_ff[hpsf_pkg::LANE_W-1:0]] <= entry_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // primary group parked while the secondary group is read
   always_ff @(posedge clock) begin
      if (state_ff == hpsf_pkg::ST_READ_S) begin
         prim_ff <= rd_data_ff;
      end
   end

   // ---------------------------------------------------------------------
   // group search
   // ---------------------------------------------------------------------
   logic [hpsf_pkg::WORD_W-1:0]       cmp_s;
   logic [hpsf_pkg::SLOTS_PER_GROUP-1:0] match_p, match_s, free_p, free_s;
   logic                              any_mp, any_ms, any_fp, any_fs;
   logic [hpsf_pkg::LANE_W-1:0]       lane_mp, lane_ms, lane_fp, lane_fs;

   always_comb begin
      cmp_s = entry_ff | hpsf_pkg::H_BIT;
      for (int i = 0; i < hpsf_pkg::SLOTS_PER_GROUP; i++) begin
         match_p[i] = (prim_ff[i] == entry_ff);
         match_s[i] = (rd_data_ff[i] == cmp_s);
         free_p[i]  = !prim_ff[i][hpsf_pkg::V_POS];
         free_s[i]  = !rd_data_ff[i][hpsf_pkg::V_POS];
      end
      any_mp = |match_p;
      any_ms = |match_s;
      any_fp = |free_p;
      any_fs = |free_s;
      // lowest slot wins: scan from the top down
      lane_mp = '0;
      lane_ms = '0;
      lane_fp = '0;
      lane_fs = '0;
      for (int i = hpsf_pkg::SLOTS_PER_GROUP - 1; i >= 0; i--) begin
         if (match_p[i]) lane_mp = hpsf_pkg::LANE_W'(i);
         if (match_s[i]) lane_ms = hpsf_pkg::LANE_W'(i);
         if (free_p[i])  lane_fp = hpsf_pkg::LANE_W'(i);
         if (free_s[i])  lane_fs = hpsf_pkg::LANE_W'(i);
      end
   end

   // ---------------------------------------------------------------------
   // result forming
   // ---------------------------------------------------------------------
   hpsf_pkg::outcome_type        res_outcome;
   logic [hpsf_pkg::LANE_W-1:0]  res_lane;
   logic                         res_sec;
   logic [hpsf_pkg::WORD_W-1:0]  addr_p, addr_s, res_base;
   logic [hpsf_pkg::WORD_W-1:0]  res_address;
   logic [hpsf_pkg::SLOT_W-1:0]  res_slot;
   logic [hpsf_pkg::WORD_W-1:0]  res_entry;
   logic                         res_repl;

   always_comb begin
      steal_in = steal_ff;
      addr_p   = table_base_ff | (hpsf_pkg::WORD_W'(grp_p_ff) << 6);
      addr_s   = addr_p ^ (hpsf_pkg::WORD_W'(group_mask_ff) << 6);

      // priority: match primary, match secondary, free primary,
      // free secondary, then steal a primary slot
      if (present_ff && any_mp) begin
         res_outcome = hpsf_pkg::OUT_MATCH_P;
         res_lane    = lane_mp;
      end else if (present_ff && any_ms) begin
         res_outcome = hpsf_pkg::OUT_MATCH_S;
         res_lane    = lane_ms;
      end else if (any_fp) begin
         res_outcome = hpsf_pkg::OUT_FREE_P;
         res_lane    = lane_fp;
      end else if (any_fs) begin
         res_outcome = hpsf_pkg::OUT_FREE_S;
         res_lane    = lane_fs;
      end else begin
         res_outcome = hpsf_pkg::OUT_STOLEN;
         // round-robin counter is bumped before use
         steal_in    = steal_ff + 3'd1;
         res_lane    = steal_in;
      end

      res_sec  = (res_outcome == hpsf_pkg::OUT_MATCH_S) ||
                 (res_outcome == hpsf_pkg::OUT_FREE_S);
      res_repl = (res_outcome == hpsf_pkg::OUT_MATCH_P) ||
                 (res_outcome == hpsf_pkg::OUT_MATCH_S);
      res_base = res_sec ? addr_s : addr_p;

      res_address = res_base + (hpsf_pkg::WORD_W'(res_lane) << 3);
      res_slot    = {(res_sec ? red_s_ff : red_p_ff), res_lane};
      res_entry   = res_sec ? cmp_s : entry_ff;
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   logic                         rsp_valid_ff;
   logic [hpsf_pkg::WORD_W-1:0]  rsp_address_ff;
   logic [hpsf_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [hpsf_pkg::WORD_W-1:0]  rsp_entry_ff;
   logic                         rsp_repl_ff;
   hpsf_pkg::outcome_type        rsp_outcome_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = out_free &&
                     ((state_ff == hpsf_pkg::ST_WRITE) || (state_ff == hpsf_pkg::ST_EVAL));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (state_ff == hpsf_pkg::ST_WRITE) begin
            rsp_address_ff <= table_base_ff + (hpsf_pkg::WORD_W'(wslot_ff) << 3);
            rsp_slot_ff    <= wslot_ff;
            rsp_entry_ff   <= entry_ff;
            rsp_repl_ff    <= 1'b0;
            rsp_outcome_ff <= hpsf_pkg::OUT_WRITE_DONE;
         end else begin
            rsp_address_ff <= res_address;
            rsp_slot_ff    <= res_slot;
            rsp_entry_ff   <= res_entry;
            rsp_repl_ff    <= res_repl;
            rsp_outcome_ff <= res_outcome;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.slot_address = rsp_address_ff;
   assign rsp_bus.slot_number  = rsp_slot_ff;
   assign rsp_bus.entry_out    = rsp_entry_ff;
   assign rsp_bus.replaced     = rsp_repl_ff;
   assign rsp_bus.outcome      = rsp_outcome_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hpsf_pkg::ST_CLEAR;
         clr_row_ff <= '0;
         steal_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_we) begin
            clr_row_ff <= clr_row_ff + ROW_W'(1);
         end
         // counter only moves when a stolen slot is handed out
         if (out_load && (state_ff == hpsf_pkg::ST_EVAL)) begin
            steal_ff <= steal_in;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hpsf_pkg::ST_CLEAR: begin
            if (clr_row_ff == LAST_ROW) state_in = hpsf_pkg::ST_IDLE;
         end
         hpsf_pkg::ST_IDLE: begin
            if (req_take) state_in = hpsf_pkg::ST_REDUCE;
         end
         hpsf_pkg::ST_REDUCE: begin
            state_in = (cmd_ff == hpsf_pkg::CMD_FIND) ? hpsf_pkg::ST_READ_P
                                                      : hpsf_pkg::ST_WRITE;
         end
         hpsf_pkg::ST_WRITE: begin
            if (out_free) state_in = hpsf_pkg::ST_IDLE;
         end
         hpsf_pkg::ST_READ_P: begin
            state_in = hpsf_pkg::ST_READ_S;
         end
         hpsf_pkg::ST_READ_S: begin
            state_in = hpsf_pkg::ST_EVAL;
         end
         hpsf_pkg::ST_EVAL: begin
            if (out_free) state_in = hpsf_pkg::ST_IDLE;
         end
         default: state_in = hpsf_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // no request is taken while the table is being cleared
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpsf_pkg::ST_CLEAR) |-> !req_bus.ready)
      else $error("request accepted during clearing pass");

   // the secondary read always follows the primary read
   a_read_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpsf_pkg::ST_READ_P) |=> (state_ff == hpsf_pkg::ST_READ_S))
      else $error("secondary group read did not follow primary read");

   // the steal counter moves only with a stolen-slot result
   a_steal_moves: assert property (@(posedge clock) disable iff (reset)
      (steal_ff != $past(steal_ff)) |->
         (rsp_valid_ff && (rsp_outcome_ff == hpsf_pkg::OUT_STOLEN)))
      else $error("steal counter moved without a stolen result");

   // a loaded result is presented on rsp_bus.valid and not lost
   a_load_then_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

@@ dv/hashed_pte_slot_finder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_pte_slot_finder_checker
// watches both channels and the csr port, keeps its own copy of the table,
// predicts the chosen slot of every request and compares each result with it
// ----------------------------------------------------------------------------
module hashed_pte_slot_finder_checker
   import hpsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   hpsf_req_if                   req_mon,
   hpsf_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0]     csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           results_seen
);

   localparam int TABLE_SLOTS = NUM_GROUPS_DEF * SLOTS_PER_GROUP;

   typedef struct {
      logic [WORD_W-1:0] slot_address;
      logic [SLOT_W-1:0] slot_number;
      logic [WORD_W-1:0] entry_out;
      logic              replaced;
      outcome_type       outcome;
   } slot_choice_type;

   logic [WORD_W-1:0]  pte_words [TABLE_SLOTS];
   logic [LANE_W-1:0]  steal_ptr;
   logic [WORD_W-1:0]  base_copy;
   logic [GROUP_W-1:0] mask_copy;
   slot_choice_type    pending_choices [$];

   // applies a write to the table copy and returns the slot that a request picks
   function automatic slot_choice_type choose_slot(
      logic cmd, logic [WORD_W-1:0] addr, logic [WORD_W-1:0] entry,
      logic present, logic [SLOT_W-1:0] wslot);
      slot_choice_type    c;
      logic [18:0]        hash;
      logic [GROUP_W-1:0] grp_p;
      logic [GROUP_W-1:0] grp_s;
      logic [SLOT_W-1:0]  idx_p;
      logic [SLOT_W-1:0]  idx_s;
      logic [WORD_W-1:0]  addr_p;
      logic [WORD_W-1:0]  addr_s;
      logic [WORD_W-1:0]  hword;
      bit                 found;
      c.replaced  = 1'b0;
      c.entry_out = entry;
      if (cmd == CMD_WRITE) begin
         pte_words[wslot] = entry;
         c.slot_address = base_copy + {16'd0, wslot, 3'd0};
         c.slot_number  = wslot;
         c.outcome      = OUT_WRITE_DONE;
         return c;
      end
      hash   = {3'd0, addr[27:12]} ^ entry[25:7];
      grp_p  = hash[GROUP_W-1:0] & mask_copy;
      grp_s  = grp_p ^ mask_copy;
      idx_p  = {grp_p, 3'd0};
      idx_s  = {grp_s, 3'd0};
      addr_p = base_copy | {16'd0, grp_p, 6'd0};
      addr_s = addr_p ^ {16'd0, mask_copy, 6'd0};
      hword  = entry | H_BIT;
      found  = 0;
      if (present) begin
         for (int lane = 0; lane < SLOTS_PER_GROUP; lane++)
            if (!found && pte_words[idx_p + SLOT_W'(lane)] === entry) begin
               c = '{addr_p + 32'(lane * 8), idx_p + SLOT_W'(lane), entry, 1'b1,
                     OUT_MATCH_P};
               found = 1;
            end
         for (int lane = 0; lane < SLOTS_PER_GROUP; lane++)
            if (!found && pte_words[idx_s + SLOT_W'(lane)] === hword) begin
               c = '{addr_s + 32'(lane * 8), idx_s + SLOT_W'(lane), hword, 1'b1,
                     OUT_MATCH_S};
               found = 1;
            end
      end
      for (int lane = 0; lane < SLOTS_PER_GROUP; lane++)
         if (!found && !pte_words[idx_p + SLOT_W'(lane)][V_POS]) begin
            c = '{addr_p + 32'(lane * 8), idx_p + SLOT_W'(lane), entry, 1'b0,
                  OUT_FREE_P};
            found = 1;
         end
      for (int lane = 0; lane < SLOTS_PER_GROUP; lane++)
         if (!found && !pte_words[idx_s + SLOT_W'(lane)][V_POS]) begin
            c = '{addr_s + 32'(lane * 8), idx_s + SLOT_W'(lane), hword, 1'b0,
                  OUT_FREE_S};
            found = 1;
         end
      if (!found) begin
         // round robin pointer moves before it is used
         steal_ptr = steal_ptr + 3'd1;
         c = '{addr_p + {26'd0, steal_ptr, 3'd0}, idx_p + {10'd0, steal_ptr}, entry,
               1'b0, OUT_STOLEN};
      end
      return c;
   endfunction

   function automatic int report_field(string name, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (want === got) return 0;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      slot_choice_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) pte_words[i] = '0;
         steal_ptr = '0;
         base_copy = '0;
         mask_copy = GROUP_MASK_RESET;
         pending_choices.delete();
         mismatch_count <= 0;
         results_seen   <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen <= results_seen + 1;
            if (pending_choices.size() == 0) begin
               $error("result with no request waiting, slot_number 0x%0h",
                      rsp_mon.slot_number);
               errs = 1;
            end else begin
               want = pending_choices.pop_front();
               errs += report_field("slot_address", want.slot_address,
                                    rsp_mon.slot_address);
               errs += report_field("slot_number", want.slot_number, rsp_mon.slot_number);
               errs += report_field("entry_out", want.entry_out, rsp_mon.entry_out);
               errs += report_field("replaced", want.replaced, rsp_mon.replaced);
               errs += report_field("outcome", want.outcome, rsp_mon.outcome);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_choices.push_back(choose_slot(req_mon.cmd, req_mon.address,
                                                  req_mon.entry_word, req_mon.present,
                                                  req_mon.write_slot));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TABLE_BASE: base_copy = csr_wdata;
               CSR_GROUP_MASK: mask_copy = csr_wdata[GROUP_W-1:0];
               default: ;
            endcase
         end
         mismatch_count <= mismatch_count + errs;
      end
   end

endmodule

@@ dv/hashed_pte_slot_finder_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_pte_slot_finder_top_test
// drives table writes and slot searches into the slot finder under several
// table layouts and pacing modes; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module hashed_pte_slot_finder_top_test;
   import hpsf_pkg::*;

   // cycles with no request and no result taken before the run is called hung;
   // covers the clearing pass after reset plus long receiver stalls
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 60;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [WORD_W-1:0]     csr_wdata;

   hpsf_req_if req_bus ();
   hpsf_rsp_if rsp_bus ();

   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned sent_count    = 0;
   int unsigned quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;

   // group mask as last written, used to aim requests at chosen groups
   logic [GROUP_W-1:0] mask_now;

   hashed_pte_slot_finder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hashed_pte_slot_finder_checker slot_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_seen   (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side back pressure, percentage set per phase
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // hang detection: any accepted request or result restarts the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // a first pte word: valid set, secondary hash flag clear
   function automatic logic [WORD_W-1:0] pte_word();
      logic [WORD_W-1:0] w;
      w = $urandom();
      w[V_POS] = 1'b1;
      w = w & ~H_BIT;
      return w;
   endfunction

   // primary group that the hash picks for this address and entry
   function automatic logic [GROUP_W-1:0] home_group(logic [WORD_W-1:0] addr,
                                                     logic [WORD_W-1:0] entry);
      return (addr[21:12] ^ entry[16:7]) & mask_now;
   endfunction

   // one request; idles first when the sender is paced, then holds until taken
   task automatic send_request(input logic cmd, input logic [WORD_W-1:0] addr,
                               input logic [WORD_W-1:0] entry, input logic present,
                               input logic [SLOT_W-1:0] wslot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.address    <= addr;
      req_bus.entry_word <= entry;
      req_bus.present    <= present;
      req_bus.write_slot <= wslot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   // stop sending until every request has come back as a result
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_seen != sent_count) @(posedge clock);
   endtask

   // make all eight slots of a group valid with random words
   task automatic fill_group(input logic [GROUP_W-1:0] grp);
      for (int lane = 0; lane < SLOTS_PER_GROUP; lane++)
         send_request(CMD_WRITE, $urandom(), pte_word(), 1'($urandom_range(1)),
                      {grp, 3'(lane)});
   endtask

   initial begin
      logic [WORD_W-1:0]  a;
      logic [WORD_W-1:0]  e;
      logic [WORD_W-1:0]  b;
      logic [GROUP_W-1:0] g;
      logic [GROUP_W-1:0] m;
      int unsigned        goal;
      int                 pick;
      int                 k;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_WRITE;
      req_bus.address    <= '0;
      req_bus.entry_word <= '0;
      req_bus.present    <= 1'b0;
      req_bus.write_slot <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_TABLE_BASE;
      csr_wdata          <= '0;
      reset              <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // layout changes only with the block idle and drained
         wait_for_results();
         repeat (10) @(posedge clock);
         case (phase)
            0: begin b = 32'h0000_0000; m = 10'h3ff; end
            1: begin b = 32'hffff_ffc0; m = 10'h000; end
            2: begin b = $urandom() & 32'hffff_fe00; m = 10'h007; end
            3: begin b = 32'hffff_0000; m = 10'h3ff; end
            // unaligned base and a mask that need not be 2^k - 1
            4: begin b = $urandom(); m = 10'($urandom_range(1023)); end
            5: begin b = 32'h0000_0080; m = 10'h001; end
            6: begin
               k = $urandom_range(10);
               m = 10'((1 << k) - 1);
               b = $urandom() & ~((32'(m) + 32'd1) * 32'd64 - 32'd1);
            end
            default: begin b = 32'hffff_ffff; m = 10'h3ff; end
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= CSR_TABLE_BASE;
         csr_wdata <= b;
         @(posedge clock);
         csr_index <= CSR_GROUP_MASK;
         csr_wdata <= {{(WORD_W-GROUP_W){1'b0}}, m};
         @(posedge clock);
         csr_wr_en <= 1'b0;
         mask_now = m;

         // pacing: none, sender idle, receiver stall, both lightly
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 68; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 68; end
            default: begin send_idle_pct = 15; stall_pct <= 15; end
         endcase

         if (phase == 0) begin
            // extremes of the write command
            send_request(CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 1'b0, 13'h0000);
            send_request(CMD_WRITE, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 13'h1fff);
            // group 0 is still empty, which gives a free primary slot
            send_request(CMD_FIND, 32'h0000_0000, 32'h8000_0000, 1'b0, 13'h0000);
            // all ones hashes to group 0, whose secondary holds the all ones word
            send_request(CMD_FIND, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 13'h1fff);
            // exact match in the primary group
            a = 32'h0123_4000;
            e = 32'h8abc_de05;
            g = home_group(a, e);
            send_request(CMD_WRITE, 32'h0, e, 1'b0, {g, 3'd5});
            send_request(CMD_FIND, a, e, 1'b1, 13'h0);
            // match in the secondary group, stored with the hash flag
            a = 32'h0fed_c000;
            e = 32'h8123_4527;
            g = home_group(a, e);
            send_request(CMD_WRITE, 32'h0, e | H_BIT, 1'b0, {g ^ mask_now, 3'd2});
            send_request(CMD_FIND, a, e, 1'b1, 13'h0);
            // primary group full, so the secondary group takes it
            a = 32'h0555_5000;
            e = 32'h8765_4301;
            g = home_group(a, e);
            fill_group(g);
            send_request(CMD_FIND, a, e, 1'b0, 13'h0);
            // both groups full: two steals in a row, one with the flag already set
            fill_group(g ^ mask_now);
            send_request(CMD_FIND, a, e | H_BIT, 1'b1, 13'h0);
            send_request(CMD_FIND, a, e, 1'b0, 13'h0);
         end

         // random part: mostly aimed sequences, the rest plain traffic
         goal = sent_count + PHASE_ITEMS;
         while (sent_count < goal) begin
            pick = $urandom_range(99);
            a = $urandom();
            e = pte_word();
            g = home_group(a, e);
            if (pick < 25) begin
               send_request(CMD_WRITE, $urandom(), e, 1'($urandom_range(1)),
                            {g, 3'($urandom_range(7))});
               send_request(CMD_FIND, a, e, 1'b1, SLOT_W'($urandom()));
            end else if (pick < 40) begin
               send_request(CMD_WRITE, $urandom(), e | H_BIT, 1'($urandom_range(1)),
                            {g ^ mask_now, 3'($urandom_range(7))});
               send_request(CMD_FIND, a, e, ($urandom_range(4) != 0), SLOT_W'($urandom()));
            end else if (pick < 50) begin
               fill_group(g);
               send_request(CMD_FIND, a, e, 1'($urandom_range(1)), SLOT_W'($urandom()));
            end else if (pick < 55) begin
               fill_group(g);
               fill_group(g ^ mask_now);
               send_request(CMD_FIND, a, e, 1'($urandom_range(1)), SLOT_W'($urandom()));
            end else if (pick < 62) begin
               // invalidate one slot of the home group, then search
               send_request(CMD_WRITE, $urandom(), $urandom() & 32'h7fff_ffff,
                            1'($urandom_range(1)), {g, 3'($urandom_range(7))});
               send_request(CMD_FIND, a, e, 1'($urandom_range(1)), SLOT_W'($urandom()));
            end else if (pick < 85) begin
               send_request(CMD_FIND, a, ($urandom_range(1) ? e : $urandom()),
                            1'($urandom_range(1)), SLOT_W'($urandom()));
            end else begin
               send_request(CMD_WRITE, a, $urandom(), 1'($urandom_range(1)),
                            SLOT_W'($urandom()));
            end
            // now and then let the block drain completely
            if ($urandom_range(39) == 0) wait_for_results();
         end
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_seen == sent_count)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hpsf_pkg.sv
rtl/hpsf_req_if.sv
rtl/hpsf_rsp_if.sv
rtl/hashed_pte_slot_finder_top.sv
dv/hashed_pte_slot_finder_checker.sv
dv/hashed_pte_slot_finder_top_test.sv
